### design/json_string_unescape_utf8_defines.svh
// Assertion macros shared by the checker of the JSON string unescaper.
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define JSU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define JSU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define JSU_ASSERT_RST(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/jsu_pkg.sv
// Types, constants and helper functions of the JSON string unescaper.
package jsu_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       text_ends;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] status;
      logic       last_of_run;
   } rsp_type;

   // Result status codes
   localparam logic [2:0] ST_DATA      = 3'd0;
   localparam logic [2:0] ST_CLOSED    = 3'd1;
   localparam logic [2:0] ST_NO_QUOTE  = 3'd2;
   localparam logic [2:0] ST_ESC_CUT   = 3'd3;
   localparam logic [2:0] ST_BAD_ESC   = 3'd4;
   localparam logic [2:0] ST_BAD_U     = 3'd5;
   localparam logic [2:0] ST_UNCLOSED  = 3'd6;

   // Scanner modes
   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_BODY,
      MODE_ESC,
      MODE_HEX,
      MODE_HWAIT,
      MODE_HBS,
      MODE_HHEX
   } mode_type;

   // Characters of note
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U      = 8'h75;

   // Code point constants
   localparam logic [15:0] SURR_HI_FIRST = 16'hD800;
   localparam logic [15:0] SURR_HI_LAST  = 16'hDBFF;
   localparam logic [15:0] SURR_LO_FIRST = 16'hDC00;
   localparam logic [15:0] SURR_LO_LAST  = 16'hDFFF;
   localparam logic [20:0] CP_SUPP_BASE  = 21'h10000;
   localparam logic [20:0] CP_REPLACE    = 21'h0FFFD;
   localparam logic [20:0] CP_TWO_BYTE   = 21'h00080;
   localparam logic [20:0] CP_THREE_BYTE = 21'h00800;
   localparam logic [7:0]  UTF8_LEAD2    = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3    = 8'hE0;
   localparam logic [7:0]  UTF8_LEAD4    = 8'hF0;
   localparam logic [7:0]  UTF8_CONT     = 8'h80;

   // Work for the back end: up to two code points, then one plain result
   typedef struct packed {
      logic        cp0_v;
      logic [20:0] cp0;
      logic        cp1_v;
      logic [15:0] cp1;
      logic        tail_v;
      logic [7:0]  tail_byte;
      logic [2:0]  tail_status;
   } job_type;

   // Hex digit decode: {valid, value}
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [7:0] t;
      t = 8'h00;
      if (c inside {[8'h30:8'h39]}) begin
         t = c - 8'h30;
         return {1'b1, t[3:0]};
      end else if (c inside {[8'h61:8'h66]}) begin
         t = c - 8'h57;
         return {1'b1, t[3:0]};
      end else if (c inside {[8'h41:8'h46]}) begin
         t = c - 8'h37;
         return {1'b1, t[3:0]};
      end
      return 5'h00;
   endfunction

   // Single-letter escapes: {valid, decoded byte}; 'u' is handled apart
   function automatic logic [8:0] esc_map(input logic [7:0] c);
      case (c)
         8'h22:   return {1'b1, 8'h22};
         8'h5C:   return {1'b1, 8'h5C};
         8'h2F:   return {1'b1, 8'h2F};
         8'h62:   return {1'b1, 8'h08};
         8'h66:   return {1'b1, 8'h0C};
         8'h6E:   return {1'b1, 8'h0A};
         8'h72:   return {1'b1, 8'h0D};
         8'h74:   return {1'b1, 8'h09};
         default: return 9'h000;
      endcase
   endfunction

   function automatic logic is_high_surr(input logic [15:0] v);
      return (v >= SURR_HI_FIRST) && (v <= SURR_HI_LAST);
   endfunction

   function automatic logic is_low_surr(input logic [15:0] v);
      return (v >= SURR_LO_FIRST) && (v <= SURR_LO_LAST);
   endfunction

   // Number of UTF-8 bytes for a code point
   function automatic logic [2:0] utf8_len(input logic [20:0] cp);
      if (cp < CP_TWO_BYTE) begin
         return 3'd1;
      end else if (cp < CP_THREE_BYTE) begin
         return 3'd2;
      end else if (cp < CP_SUPP_BASE) begin
         return 3'd3;
      end
      return 3'd4;
   endfunction

   // One byte of the UTF-8 encoding of cp, given its length
   function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
                                            input logic [2:0]  len,
                                            input logic [1:0]  idx);
      logic [7:0] c0;
      logic [7:0] c1;
      logic [7:0] c2;
      c0 = UTF8_CONT | {2'b00, cp[5:0]};
      c1 = UTF8_CONT | {2'b00, cp[11:6]};
      c2 = UTF8_CONT | {2'b00, cp[17:12]};
      case (len)
         3'd1:    return cp[7:0];
         3'd2:    return (idx == 2'd0) ? (UTF8_LEAD2 | {3'b000, cp[10:6]}) : c0;
         3'd3: begin
            case (idx)
               2'd0:    return UTF8_LEAD3 | {4'b0000, cp[15:12]};
               2'd1:    return c1;
               default: return c0;
            endcase
         end
         default: begin
            case (idx)
               2'd0:    return UTF8_LEAD4 | {5'b00000, cp[20:18]};
               2'd1:    return c2;
               2'd2:    return c1;
               default: return c0;
            endcase
         end
      endcase
   endfunction

endpackage

### design/jsu_front.sv
// Front end: scans text bytes, tracks escapes and surrogates, emits job beats.
module jsu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  jsu_pkg::req_type req_data,
   output logic             push,
   output jsu_pkg::job_type push_job
);
   import jsu_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [15:0] accum_ff, accum_in;
   logic [1:0]  count_ff, count_in;
   logic [9:0]  held_ff, held_in;

   logic [7:0]  b;
   logic [4:0]  dig;
   logic [8:0]  esc;
   logic [15:0] nacc;
   logic        last_digit;
   logic        go_idle;
   job_type     job;

   assign b          = req_data.in_byte;
   assign dig        = hex_val(b);
   assign esc        = esc_map(b);
   assign nacc       = {accum_ff[11:0], dig[3:0]};
   assign last_digit = (count_ff == 2'd3);

   // Hold scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         accum_ff <= '0;
         count_ff <= '0;
         held_ff  <= '0;
      end else begin
         mode_ff  <= mode_in;
         accum_ff <= accum_in;
         count_ff <= count_in;
         held_ff  <= held_in;
      end
   end

   // Decode one beat into the next state and a job
   always_comb begin
      mode_in  = mode_ff;
      accum_in = accum_ff;
      count_in = count_ff;
      held_in  = held_ff;
      go_idle  = 1'b0;
      job      = '0;
      if (fire) begin
         if (req_data.text_ends) begin
            go_idle         = 1'b1;
            job.tail_v      = 1'b1;
            case (mode_ff)
               MODE_BODY:  job.tail_status = ST_UNCLOSED;
               MODE_ESC:   job.tail_status = ST_ESC_CUT;
               MODE_HEX:   job.tail_status = ST_BAD_U;
               MODE_HWAIT: begin
                  job.cp0_v       = 1'b1;
                  job.cp0         = CP_REPLACE;
                  job.tail_status = ST_UNCLOSED;
               end
               MODE_HBS: begin
                  job.cp0_v       = 1'b1;
                  job.cp0         = CP_REPLACE;
                  job.tail_status = ST_ESC_CUT;
               end
               MODE_HHEX: begin
                  job.cp0_v       = 1'b1;
                  job.cp0         = CP_REPLACE;
                  job.tail_status = ST_BAD_U;
               end
               default:    job.tail_status = ST_NO_QUOTE;
            endcase
         end else begin
            case (mode_ff)
               MODE_BODY: begin
                  if (b == CH_QUOTE) begin
                     job.tail_v      = 1'b1;
                     job.tail_status = ST_CLOSED;
                     go_idle         = 1'b1;
                  end else if (b == CH_BSLASH) begin
                     mode_in = MODE_ESC;
                  end else begin
                     job.tail_v    = 1'b1;
                     job.tail_byte = b;
                  end
               end
               MODE_ESC: begin
                  if (b == CH_U) begin
                     accum_in = '0;
                     count_in = '0;
                     mode_in  = MODE_HEX;
                  end else if (esc[8]) begin
                     job.tail_v    = 1'b1;
                     job.tail_byte = esc[7:0];
                     mode_in       = MODE_BODY;
                  end else begin
                     job.tail_v      = 1'b1;
                     job.tail_status = ST_BAD_ESC;
                     go_idle         = 1'b1;
                  end
               end
               MODE_HEX: begin
                  if (!dig[4]) begin
                     job.tail_v      = 1'b1;
                     job.tail_status = ST_BAD_U;
                     go_idle         = 1'b1;
                  end else if (last_digit) begin
                     accum_in = '0;
                     count_in = '0;
                     if (is_high_surr(nacc)) begin
                        held_in = nacc[9:0];
                        mode_in = MODE_HWAIT;
                     end else begin
                        job.cp0_v = 1'b1;
                        job.cp0   = is_low_surr(nacc) ? CP_REPLACE : {5'b00000, nacc};
                        mode_in   = MODE_BODY;
                     end
                  end else begin
                     accum_in = nacc;
                     count_in = count_ff + 2'd1;
                  end
               end
               MODE_HWAIT: begin
                  if (b == CH_BSLASH) begin
                     mode_in = MODE_HBS;
                  end else begin
                     // Lone high surrogate, then the byte as in the body
                     job.cp0_v  = 1'b1;
                     job.cp0    = CP_REPLACE;
                     job.tail_v = 1'b1;
                     held_in    = '0;
                     if (b == CH_QUOTE) begin
                        job.tail_status = ST_CLOSED;
                        go_idle         = 1'b1;
                     end else begin
                        job.tail_byte = b;
                        mode_in       = MODE_BODY;
                     end
                  end
               end
               MODE_HBS: begin
                  if (b == CH_U) begin
                     accum_in = '0;
                     count_in = '0;
                     mode_in  = MODE_HHEX;
                  end else begin
                     // Lone high surrogate, then the escape letter
                     job.cp0_v  = 1'b1;
                     job.cp0    = CP_REPLACE;
                     job.tail_v = 1'b1;
                     held_in    = '0;
                     if (esc[8]) begin
                        job.tail_byte = esc[7:0];
                        mode_in       = MODE_BODY;
                     end else begin
                        job.tail_status = ST_BAD_ESC;
                        go_idle         = 1'b1;
                     end
                  end
               end
               MODE_HHEX: begin
                  if (!dig[4]) begin
                     job.cp0_v       = 1'b1;
                     job.cp0         = CP_REPLACE;
                     job.tail_v      = 1'b1;
                     job.tail_status = ST_BAD_U;
                     go_idle         = 1'b1;
                  end else if (last_digit) begin
                     accum_in  = '0;
                     count_in  = '0;
                     held_in   = '0;
                     job.cp0_v = 1'b1;
                     if (is_low_surr(nacc)) begin
                        // Combine the pair into a supplementary code point
                        job.cp0 = CP_SUPP_BASE + {1'b0, held_ff, nacc[9:0]};
                        mode_in = MODE_BODY;
                     end else begin
                        // Lone high surrogate; decode the second escape alone
                        job.cp0 = CP_REPLACE;
                        if (is_high_surr(nacc)) begin
                           held_in = nacc[9:0];
                           mode_in = MODE_HWAIT;
                        end else begin
                           job.cp1_v = 1'b1;
                           job.cp1   = is_low_surr(nacc) ? CP_REPLACE[15:0] : nacc;
                           mode_in   = MODE_BODY;
                        end
                     end
                  end else begin
                     accum_in = nacc;
                     count_in = count_ff + 2'd1;
                  end
               end
               default: begin
                  if (b == CH_QUOTE) begin
                     accum_in = '0;
                     count_in = '0;
                     held_in  = '0;
                     mode_in  = MODE_BODY;
                  end else begin
                     job.tail_v      = 1'b1;
                     job.tail_status = ST_NO_QUOTE;
                     go_idle         = 1'b1;
                  end
               end
            endcase
         end
         if (go_idle) begin
            mode_in  = MODE_IDLE;
            accum_in = '0;
            count_in = '0;
            held_in  = '0;
         end
      end
   end

   // Drop beats that yield no result
   assign push     = fire && (job.cp0_v || job.cp1_v || job.tail_v);
   assign push_job = job;

endmodule

### design/jsu_queue.sv
// Job queue between the front and back ends.
module jsu_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::job_type push_job,
   output logic             full,
   output logic             head_valid,
   output jsu_pkg::job_type head_job,
   input  logic             pop
);
   import jsu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // Store pushed jobs
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];

endmodule

### design/jsu_back.sv
// Back end: expands each job into result beats through an output register.
module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  jsu_pkg::job_type head_job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jsu_pkg::rsp_type rsp_data
);
   import jsu_pkg::*;

   logic [2:0] pos_ff, pos_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic [3:0] n0;
   logic [3:0] n1;
   logic [3:0] n01;
   logic [3:0] total;
   logic [3:0] pos4;
   logic [3:0] off;
   logic       advance;
   logic       last;
   rsp_type    cur;

   // Byte counts of the job's segments
   assign n0    = head_job.cp0_v ? {1'b0, utf8_len(head_job.cp0)} : 4'd0;
   assign n1    = head_job.cp1_v ? {1'b0, utf8_len({5'b00000, head_job.cp1})} : 4'd0;
   assign n01   = n0 + n1;
   assign total = n01 + {3'b000, head_job.tail_v};
   assign pos4  = {1'b0, pos_ff};
   assign off   = pos4 - n0;
   assign last  = ((pos4 + 4'd1) == total);

   // Select the result at the current position
   always_comb begin
      cur.last_of_run = last;
      cur.status      = ST_DATA;
      if (pos4 < n0) begin
         cur.out_byte = utf8_byte(head_job.cp0, n0[2:0], pos_ff[1:0]);
      end else if (pos4 < n01) begin
         cur.out_byte = utf8_byte({5'b00000, head_job.cp1}, n1[2:0], off[1:0]);
      end else begin
         cur.out_byte = head_job.tail_byte;
         cur.status   = head_job.tail_status;
      end
   end

   assign advance = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop     = advance && last;

   // Load the output register and step through the job
   always_comb begin
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = cur;
         pos_in       = last ? 3'd0 : pos_ff + 3'd1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### design/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper with UTF-8 output.
//
// Input channel req_*: one text byte per beat (req_data.in_byte), or a
// text-end marker (req_data.text_ends). The first byte of a string must be
// the opening quote. Result channel rsp_*: one decoded UTF-8 byte or one
// status code per beat; last_of_run flags the final result of an input beat.
// Beats that only advance inside an escape, or hold a high surrogate, give
// no result.
// A QUEUE_DEPTH-entry job queue decouples front and back end; the first
// result of a beat is registered in the queue, then in the output register.
// Throughput: one input beat per cycle while each yields one result and the
// receiver is ready; a beat yields up to six results (a replaced surrogate
// and a three-byte code). Front end: one beat per cycle unless the queue is
// full; back end: one result per cycle unless the receiver stalls.
// Reset returns the scanner to idle, awaiting an opening quote, and empties
// the queue and the output register. When the receiver stalls, the output
// register holds; the queue fills and req_ready then drops until it drains.
module json_string_unescape_utf8 #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  jsu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jsu_pkg::rsp_type rsp_data
);
   import jsu_pkg::*;

   logic    fire;
   logic    push;
   logic    full;
   logic    head_valid;
   logic    pop;
   job_type push_job;
   job_type head_job;

   assign req_ready = !full;
   assign fire      = req_valid && req_ready;

   jsu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .req_data (req_data),
      .push     (push),
      .push_job (push_job)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

### design/jsu_checker.sv
// Port-level checker for the JSON string unescaper, bound to the top level.
`include "json_string_unescape_utf8_defines.svh"

module jsu_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input jsu_pkg::rsp_type rsp_data
);
   import jsu_pkg::*;

   // A stalled result beat stays put
   `JSU_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result beat changed while stalled")

   // Status beats carry a zero byte
   `JSU_ASSERT_IMP(a_status_zero, clock, reset, rsp_valid && (rsp_data.status != ST_DATA), rsp_data.out_byte == 8'h00, "status beat with non-zero byte")

   // A status always closes the run of its input beat
   `JSU_ASSERT_IMP(a_status_last, clock, reset, rsp_valid && (rsp_data.status != ST_DATA), rsp_data.last_of_run, "status beat not last of run")

   // Reset empties the output side
   `JSU_ASSERT_RST(a_reset_empty, clock, reset, !rsp_valid, "result valid after reset")

   // Reset leaves the input side able to accept
   `JSU_ASSERT_RST(a_reset_ready, clock, reset, req_ready, "input not ready after reset")

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);

### verif/testbench.sv
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import jsu_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 30;
   localparam int RANDOM_BEATS = 300;

   // Escape letters: quote, backslash, slash, b, f, n, r, t
   localparam logic [63:0] ESC_LETTERS = {8'h22, 8'h5C, 8'h2F, 8'h62,
                                          8'h66, 8'h6E, 8'h72, 8'h74};
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;

   // Decoder mirror and queue of the UTF-8 results still due
   class utf8_scoreboard;
      localparam int MAX_REPORTS = 10;
      localparam int MAX_PER_BEAT = 6;

      mode_type    mode;
      logic [15:0] acc;
      logic [2:0]  digits;
      logic [9:0]  held;
      rsp_type     decoded_due[$];
      rsp_type     beat_out[$];
      int          mismatches;
      int          checked;
      int          status_seen[8];

      function new();
         go_idle();
         mismatches = 0;
         checked = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      static function int hex_value(logic [7:0] c);
         if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
         if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
         if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
         return -1;
      endfunction

      function void put(logic [7:0] b, logic [2:0] st);
         rsp_type r;
         if (beat_out.size() >= MAX_PER_BEAT) return;
         r.out_byte = b;
         r.status = st;
         r.last_of_run = 1'b0;
         beat_out.insert(beat_out.size(), r);
      endfunction

      function void go_idle();
         mode = MODE_IDLE;
         acc = '0;
         digits = '0;
         held = '0;
      endfunction

      function void fail(logic [2:0] st);
         put(8'h00, st);
         go_idle();
      endfunction

      function void put_utf8(logic [20:0] cp);
         if (cp < CP_TWO_BYTE) begin
            put(cp[7:0], ST_DATA);
         end else if (cp < CP_THREE_BYTE) begin
            put(UTF8_LEAD2 | {3'b000, cp[10:6]}, ST_DATA);
            put(UTF8_CONT | {2'b00, cp[5:0]}, ST_DATA);
         end else if (cp < CP_SUPP_BASE) begin
            put(UTF8_LEAD3 | {4'b0000, cp[15:12]}, ST_DATA);
            put(UTF8_CONT | {2'b00, cp[11:6]}, ST_DATA);
            put(UTF8_CONT | {2'b00, cp[5:0]}, ST_DATA);
         end else begin
            put(UTF8_LEAD4 | {5'b00000, cp[20:18]}, ST_DATA);
            put(UTF8_CONT | {2'b00, cp[17:12]}, ST_DATA);
            put(UTF8_CONT | {2'b00, cp[11:6]}, ST_DATA);
            put(UTF8_CONT | {2'b00, cp[5:0]}, ST_DATA);
         end
      endfunction

      // Four digits gathered and no high surrogate pending
      function void finish_code(logic [15:0] code);
         acc = '0;
         digits = '0;
         if (code >= SURR_HI_FIRST && code <= SURR_HI_LAST) begin
            held = code[9:0];
            mode = MODE_HWAIT;
            return;
         end
         if (code >= SURR_LO_FIRST && code <= SURR_LO_LAST) begin
            put_utf8(CP_REPLACE);
         end else begin
            put_utf8({5'b00000, code});
         end
         mode = MODE_BODY;
      endfunction

      function void body_byte(logic [7:0] b);
         if (b == CH_QUOTE) begin
            put(8'h00, ST_CLOSED);
            go_idle();
         end else if (b == CH_BSLASH) begin
            mode = MODE_ESC;
         end else begin
            put(b, ST_DATA);
         end
      endfunction

      function void take_escape(logic [7:0] b);
         logic [7:0] v;
         case (b)
            CH_QUOTE:  v = CH_QUOTE;
            CH_BSLASH: v = CH_BSLASH;
            CH_SLASH:  v = CH_SLASH;
            CH_B:      v = 8'h08;
            CH_F:      v = 8'h0C;
            CH_N:      v = 8'h0A;
            CH_R:      v = 8'h0D;
            CH_T:      v = 8'h09;
            CH_U: begin
               acc = '0;
               digits = '0;
               mode = MODE_HEX;
               return;
            end
            default: begin
               fail(ST_BAD_ESC);
               return;
            end
         endcase
         put(v, ST_DATA);
         mode = MODE_BODY;
      endfunction

      // Work out the results of one accepted input beat
      function void note_text_beat(req_type r);
         logic [7:0]  b;
         logic [20:0] cp;
         int          d;
         beat_out.delete();
         b = r.in_byte;
         if (r.text_ends) begin
            case (mode)
               MODE_BODY:  fail(ST_UNCLOSED);
               MODE_ESC:   fail(ST_ESC_CUT);
               MODE_HEX:   fail(ST_BAD_U);
               MODE_HWAIT: begin
                  put_utf8(CP_REPLACE);
                  fail(ST_UNCLOSED);
               end
               MODE_HBS: begin
                  put_utf8(CP_REPLACE);
                  fail(ST_ESC_CUT);
               end
               MODE_HHEX: begin
                  put_utf8(CP_REPLACE);
                  fail(ST_BAD_U);
               end
               default:    fail(ST_NO_QUOTE);
            endcase
         end else begin
            case (mode)
               MODE_BODY: body_byte(b);
               MODE_ESC:  take_escape(b);
               MODE_HEX: begin
                  d = hex_value(b);
                  if (d < 0) begin
                     fail(ST_BAD_U);
                  end else begin
                     acc = {acc[11:0], d[3:0]};
                     digits = digits + 3'd1;
                     if (digits >= 3'd4) finish_code(acc);
                  end
               end
               MODE_HWAIT: begin
                  if (b == CH_BSLASH) begin
                     mode = MODE_HBS;
                  end else begin
                     put_utf8(CP_REPLACE);
                     held = '0;
                     mode = MODE_BODY;
                     body_byte(b);
                  end
               end
               MODE_HBS: begin
                  if (b == CH_U) begin
                     acc = '0;
                     digits = '0;
                     mode = MODE_HHEX;
                  end else begin
                     put_utf8(CP_REPLACE);
                     held = '0;
                     take_escape(b);
                  end
               end
               MODE_HHEX: begin
                  d = hex_value(b);
                  if (d < 0) begin
                     put_utf8(CP_REPLACE);
                     fail(ST_BAD_U);
                  end else begin
                     acc = {acc[11:0], d[3:0]};
                     digits = digits + 3'd1;
                     if (digits >= 3'd4) begin
                        if (acc >= SURR_LO_FIRST && acc <= SURR_LO_LAST) begin
                           // combine the pair into one supplementary code point
                           cp = CP_SUPP_BASE + {1'b0, held, 10'b0} + {11'b0, acc[9:0]};
                           put_utf8(cp);
                           held = '0;
                           acc = '0;
                           digits = '0;
                           mode = MODE_BODY;
                        end else begin
                           put_utf8(CP_REPLACE);
                           held = '0;
                           finish_code(acc);
                        end
                     end
                  end
               end
               default: begin
                  if (b == CH_QUOTE) begin
                     acc = '0;
                     digits = '0;
                     held = '0;
                     mode = MODE_BODY;
                  end else begin
                     fail(ST_NO_QUOTE);
                  end
               end
            endcase
         end
         // flag the final result of this beat
         if (beat_out.size() > 0) begin
            beat_out[beat_out.size() - 1].last_of_run = 1'b1;
         end
         foreach (beat_out[i]) decoded_due.insert(decoded_due.size(), beat_out[i]);
      endfunction

      // Compare one accepted result with the oldest one due
      function void check_decoded(rsp_type got);
         rsp_type want;
         if (decoded_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result: byte %02h status %0d last %0b",
                        got.out_byte, got.status, got.last_of_run);
            return;
         end
         want = decoded_due.pop_front();
         checked++;
         if (got.out_byte !== want.out_byte || got.status !== want.status ||
             got.last_of_run !== want.last_of_run) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("mismatch at result %0d: ", checked,
                        "expected byte %02h status %0d last %0b, ",
                        want.out_byte, want.status, want.last_of_run,
                        "got byte %02h status %0d last %0b",
                        got.out_byte, got.status, got.last_of_run);
         end else begin
            status_seen[want.status]++;
         end
      endfunction

      function int outstanding();
         return decoded_due.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   utf8_scoreboard sb;
   bit steady_flow = 1'b0;
   int beats_sent = 0;
   int strings_sent = 0;
   int idle_cycles = 0;

   json_string_unescape_utf8 i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int draw_gap();
      return steady_flow ? 0 : int'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) return 8'h30 + {4'h0, n};
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, n - 4'd10};
   endfunction

   function automatic logic [7:0] unknown_letter();
      logic [7:0] c;
      bit         known;
      do begin
         c = 8'($urandom_range(0, 255));
         known = (c == CH_U);
         for (int i = 0; i < 8; i++) if (c == ESC_LETTERS[8*i +: 8]) known = 1'b1;
      end while (known);
      return c;
   endfunction

   // Code point that is no surrogate, weighted over the UTF-8 lengths
   function automatic logic [15:0] plain_code();
      logic [15:0] c;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 8))
               0:       c = 16'h0000;
               1:       c = 16'h007F;
               2:       c = 16'h0080;
               3:       c = 16'h07FF;
               4:       c = 16'h0800;
               5:       c = 16'hD7FF;
               6:       c = 16'hE000;
               7:       c = 16'hFFFD;
               default: c = 16'hFFFF;
            endcase
         end
         1, 2, 3: c = 16'($urandom_range(16'h0000, 16'h007F));
         4, 5, 6: c = 16'($urandom_range(16'h0080, 16'h07FF));
         default: begin
            c = 16'($urandom_range(16'h0800, 16'hF7FF));
            if (c >= SURR_HI_FIRST) c = c + 16'h0800;
         end
      endcase
      return c;
   endfunction

   function automatic logic [15:0] high_code();
      return 16'($urandom_range(SURR_HI_FIRST, SURR_HI_LAST));
   endfunction

   function automatic logic [15:0] low_code();
      return 16'($urandom_range(SURR_LO_FIRST, SURR_LO_LAST));
   endfunction

   // Present one beat and hold it until it is taken
   task automatic send_beat(input logic [7:0] b, input logic ends);
      int      gap;
      req_type beat;
      gap = draw_gap();
      beat.in_byte = b;
      beat.text_ends = ends;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_text_end();
      send_beat(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_u(input logic [15:0] code);
      send_beat(CH_BSLASH, 1'b0);
      send_beat(CH_U, 1'b0);
      for (int i = 3; i >= 0; i--) send_beat(hex_char(code[4*i +: 4]), 1'b0);
   endtask

   // \u with fewer than four digits, then a byte that is no hex digit
   task automatic send_bad_u();
      int         k;
      logic [7:0] junk;
      k = $urandom_range(0, 3);
      send_beat(CH_BSLASH, 1'b0);
      send_beat(CH_U, 1'b0);
      repeat (k) send_beat(hex_char(4'($urandom_range(0, 15))), 1'b0);
      do junk = 8'($urandom_range(0, 255));
      while (utf8_scoreboard::hex_value(junk) >= 0);
      send_beat(junk, 1'b0);
   endtask

   // \u with fewer than four digits, then the text ends
   task automatic send_cut_u();
      int k;
      k = $urandom_range(0, 3);
      send_beat(CH_BSLASH, 1'b0);
      send_beat(CH_U, 1'b0);
      repeat (k) send_beat(hex_char(4'($urandom_range(0, 15))), 1'b0);
      send_text_end();
   endtask

   // Drop valid and hold off until every result due has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // One quoted string with random content and a random ending
   task automatic send_random_string();
      int         n;
      int         pick;
      bit         open;
      logic [7:0] b;
      send_beat(CH_QUOTE, 1'b0);
      open = 1'b1;
      n = $urandom_range(0, 8);
      for (int i = 0; i < n && open; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            do b = 8'($urandom_range(0, 255));
            while (b == CH_QUOTE || b == CH_BSLASH);
            send_beat(b, 1'b0);
         end else if (pick < 55) begin
            send_beat(CH_BSLASH, 1'b0);
            send_beat(ESC_LETTERS[8*$urandom_range(0, 7) +: 8], 1'b0);
         end else if (pick < 70) begin
            send_u(plain_code());
         end else if (pick < 82) begin
            send_u(high_code());
            send_u(low_code());
         end else if (pick < 86) begin
            send_u(low_code());
         end else if (pick < 94) begin
            // high surrogate broken off by whatever follows
            send_u(high_code());
            case ($urandom_range(0, 3))
               0: begin
                  do b = 8'($urandom_range(0, 255));
                  while (b == CH_BSLASH);
                  send_beat(b, 1'b0);
                  if (b == CH_QUOTE) open = 1'b0;
               end
               1: begin
                  send_beat(CH_BSLASH, 1'b0);
                  if ($urandom_range(0, 2) == 0) begin
                     send_beat(unknown_letter(), 1'b0);
                     open = 1'b0;
                  end else begin
                     send_beat(ESC_LETTERS[8*$urandom_range(0, 7) +: 8], 1'b0);
                  end
               end
               2: begin
                  if ($urandom_range(0, 1))
                     send_u(high_code());
                  else
                     send_u(plain_code());
               end
               default: begin
                  send_bad_u();
                  open = 1'b0;
               end
            endcase
         end else if (pick < 97) begin
            send_bad_u();
            open = 1'b0;
         end else begin
            send_beat(CH_BSLASH, 1'b0);
            send_beat(unknown_letter(), 1'b0);
            open = 1'b0;
         end
      end
      if (open) begin
         case ($urandom_range(0, 9))
            7: send_text_end();
            8: begin
               send_beat(CH_BSLASH, 1'b0);
               send_text_end();
            end
            9: begin
               case ($urandom_range(0, 3))
                  0: send_cut_u();
                  1: begin
                     send_u(high_code());
                     send_text_end();
                  end
                  2: begin
                     send_u(high_code());
                     send_beat(CH_BSLASH, 1'b0);
                     send_text_end();
                  end
                  default: begin
                     send_u(high_code());
                     send_cut_u();
                  end
               endcase
            end
            default: send_beat(CH_QUOTE, 1'b0);
         endcase
      end
   endtask

   // Receiver: stall a random number of cycles before each result
   initial begin
      int gap;
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
         while (!rsp_valid) @(negedge clock);
         @(posedge clock);
      end
   end

   // Sample both channels away from the active edge; watch for a hang
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_text_beat(req_data);
         if (rsp_valid && rsp_ready) sb.check_decoded(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles, ", STALL_LIMIT,
                     "%0d results outstanding", sb.outstanding());
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   initial begin
      int random_goal;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle errors, byte extremes, unknown escape, surrogate cases, bad hex digit
      send_text_end();
      send_beat(8'hFF, 1'b0);
      send_beat(CH_QUOTE, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(CH_BSLASH, 1'b0);
      send_beat(8'h71, 1'b0);          // 'q' is no escape letter
      send_beat(CH_QUOTE, 1'b0);
      send_u(16'hDC00);                // lone low surrogate
      send_u(16'hD800);                // high surrogate, then a plain byte
      send_beat(8'h78, 1'b0);
      send_beat(CH_BSLASH, 1'b0);
      send_beat(CH_U, 1'b0);
      send_beat(8'h47, 1'b0);          // 'G' is no hex digit
      send_beat(CH_QUOTE, 1'b0);
      send_text_end();
      wait_drained();

      // Random strings with the odd stretch of noise and of steady flow
      random_goal = beats_sent + RANDOM_BEATS;
      while (beats_sent < random_goal) begin
         steady_flow = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               if ($urandom_range(0, 3) == 0) send_text_end();
               else send_beat(8'($urandom_range(0, 255)), 1'b0);
            end
         end else begin
            send_random_string();
         end
         strings_sent++;
         if (strings_sent % 25 == 0) wait_drained();
      end
      steady_flow = 1'b0;

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d text beats (%0d random strings or noise runs), ", beats_sent,
               strings_sent, "checked %0d results.", sb.checked);
      $display("Matched by status: data %0d, closed %0d, no quote %0d, ",
               sb.status_seen[ST_DATA], sb.status_seen[ST_CLOSED],
               sb.status_seen[ST_NO_QUOTE],
               "escape cut %0d, unknown escape %0d, bad u %0d, unclosed %0d",
               sb.status_seen[ST_ESC_CUT], sb.status_seen[ST_BAD_ESC],
               sb.status_seen[ST_BAD_U], sb.status_seen[ST_UNCLOSED]);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("testbench OK");
      end else begin
         $display("%0d mismatches, %0d results never arrived",
                  sb.mismatches, sb.outstanding());
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

### json_string_unescape_utf8.f
+incdir+design
design/jsu_pkg.sv
design/jsu_front.sv
design/jsu_queue.sv
design/jsu_back.sv
design/json_string_unescape_utf8.sv
design/jsu_checker.sv
verif/testbench.sv
